@@ design/rgb_to_hsv_approx_pixel_assert.svh @@
// assertion macros for the rgb to hsv pixel converter
// no dependencies; included by the top level inside its module body
`ifndef RGB_TO_HSV_APPROX_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_APPROX_PIXEL_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define RHSV_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rhsv assertion failed");

// next-cycle implication, disabled while reset is held
`define RHSV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rhsv assertion failed");

`endif

@@ design/rhsv_pkg.sv @@
// shared types, hue constants and elaboration-time lookup tables
// for the rgb to hsv pixel converter; no dependencies
package rhsv_pkg;

    // one pixel, three 8-bit channels
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // hue anchors on the 256-step wheel
    localparam logic [7:0] WHEEL_RED         = 8'd0;
    localparam logic [7:0] WHEEL_ORANGE      = 8'd32;
    localparam logic [7:0] WHEEL_YELLOW      = 8'd64;
    localparam logic [7:0] WHEEL_GREEN       = 8'd96;
    localparam logic [7:0] WHEEL_AQUA        = 8'd128;
    localparam logic [7:0] WHEEL_BLUE        = 8'd160;
    localparam logic [7:0] WHEEL_PURPLE      = 8'd192;
    localparam logic [7:0] WHEEL_PURPLE_PINK = 8'd208;
    localparam logic [7:0] WHEEL_AQUA_BLUE   = 8'd136;

    // slope factors (fractions of 256)
    localparam logic [7:0] FRAC_32_85  = 8'd96;
    localparam logic [7:0] FRAC_32_170 = 8'd48;
    localparam logic [7:0] FRAC_8_42   = 8'd48;
    localparam logic [7:0] FRAC_24_128 = 8'd48;
    localparam logic [7:0] FRAC_48_128 = 8'd96;
    localparam logic [7:0] YEL_RED_K   = 8'd47;
    localparam logic [7:0] YEL_GREEN_K = 8'd96;

    // branch offsets and pivots
    localparam logic [7:0] PIVOT_171  = 8'd171;
    localparam logic [7:0] PIVOT_85   = 8'd85;
    localparam logic [7:0] PIVOT_128  = 8'd128;
    localparam logic [7:0] ORANGE_OFS = 8'd170;
    localparam logic [7:0] ORANGE_FLR = 8'd4;

    // (i * (k + 1)) >> 8
    function automatic logic [7:0] scale8(input logic [7:0] i, input logic [7:0] k);
        logic [16:0] prod;
        prod = 17'(i) * (17'(k) + 17'd1);
        return prod[15:8];
    endfunction

    // subtract clamped at zero
    function automatic logic [7:0] ssub8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : 8'd0;
    endfunction

    // floor square root of a 16-bit value, table building only
    function automatic logic [7:0] isqrt16(input logic [15:0] x);
        logic [16:0] rem;
        logic [16:0] root;
        logic [16:0] bt;
        rem  = {1'b0, x};
        root = '0;
        bt   = 17'h04000;
        for (int i = 0; i < 8; i++) begin
            if (rem >= root + bt) begin
                rem  = rem - (root + bt);
                root = (root >> 1) + bt;
            end else begin
                root = root >> 1;
            end
            bt = bt >> 2;
        end
        return root[7:0];
    endfunction

    // 65535 / d by restoring long division, table building only
    function automatic logic [15:0] recip16(input logic [7:0] d);
        logic [15:0] quo;
        logic [8:0]  rem;
        logic [15:0] num;
        num = 16'hFFFF;
        rem = '0;
        quo = '0;
        for (int i = 15; i >= 0; i--) begin
            rem = {rem[7:0], num[i]};
            if (rem >= {1'b0, d}) begin
                rem    = rem - {1'b0, d};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // floor(sqrt(i * 256))
    function automatic logic [255:0][7:0] build_sqrt_lut();
        logic [255:0][7:0] lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = isqrt16({8'(i), 8'h00});
        end
        return lut;
    endfunction

    // 65535 / s with s = 255 - sqrt(desat * 256), zero forced to one
    function automatic logic [255:0][15:0] build_kdesat_lut();
        logic [255:0][15:0] lut;
        logic [7:0]         s;
        for (int i = 0; i < 256; i++) begin
            s = 8'hFF - isqrt16({8'(i), 8'h00});
            if (s == 8'd0) begin
                s = 8'd1;
            end
            lut[i] = recip16(s);
        end
        return lut;
    endfunction

    // 65535 / total, zero forced to one
    function automatic logic [255:0][15:0] build_ktotal_lut();
        logic [255:0][15:0] lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = recip16((i == 0) ? 8'd1 : 8'(i));
        end
        return lut;
    endfunction

    localparam logic [255:0][7:0]  SQRT_LUT   = build_sqrt_lut();
    localparam logic [255:0][15:0] KDESAT_LUT = build_kdesat_lut();
    localparam logic [255:0][15:0] KTOTAL_LUT = build_ktotal_lut();

endpackage

@@ design/rhsv_rescale.sv @@
// channel rescale: each channel times a 16-bit factor, bits 15:8 kept
// depends on rhsv_pkg (rgb_t)
module rhsv_rescale (
    input  rhsv_pkg::rgb_t pix_in,
    input  logic [15:0]    factor,
    input  logic           enable,
    output rhsv_pkg::rgb_t pix_out
);
    import rhsv_pkg::*;

    logic [23:0] prod_r;
    logic [23:0] prod_g;
    logic [23:0] prod_b;

    // three parallel 8x16 multipliers
    assign prod_r = 24'(pix_in.red)   * 24'(factor);
    assign prod_g = 24'(pix_in.green) * 24'(factor);
    assign prod_b = 24'(pix_in.blue)  * 24'(factor);

    // keep the wrapped byte, or pass through when disabled
    always_comb begin
        if (enable) begin
            pix_out.red   = prod_r[15:8];
            pix_out.green = prod_g[15:8];
            pix_out.blue  = prod_b[15:8];
        end else begin
            pix_out = pix_in;
        end
    end

endmodule

@@ design/rhsv_hue.sv @@
// hue from the rescaled channels, branching on the largest channel
// depends on rhsv_pkg (rgb_t, hue constants, scale8, ssub8)
module rhsv_hue (
    input  rhsv_pkg::rgb_t pix,
    output logic [7:0]     hue
);
    import rhsv_pkg::*;

    logic       red_top;
    logic       green_top;
    logic [7:0] base;
    logic [7:0] orange_m;
    logic [7:0] yel_sum;

    // red wins ties over green, green over blue
    assign red_top   = (pix.red >= pix.green) && (pix.red >= pix.blue);
    assign green_top = !red_top && (pix.green >= pix.blue);

    assign orange_m = pix.green + ORANGE_OFS - pix.red;
    assign yel_sum  = scale8(ssub8(PIVOT_171, pix.red), YEL_RED_K)
                    + scale8(ssub8(pix.green, PIVOT_171), YEL_GREEN_K);

    // per-sector hue before the final offset of one
    always_comb begin
        if (red_top) begin
            if (pix.green == 8'd0) begin
                base = WHEEL_PURPLE_PINK + scale8(ssub8(pix.red, PIVOT_128), FRAC_48_128);
            end else if ({1'b0, pix.red} > {pix.green, 1'b0}) begin
                base = WHEEL_RED + scale8(pix.green, FRAC_32_85);
            end else begin
                base = WHEEL_ORANGE + scale8(ssub8(orange_m, ORANGE_FLR), FRAC_32_170);
            end
        end else if (green_top) begin
            if (pix.blue == 8'd0) begin
                base = WHEEL_YELLOW + {1'b0, yel_sum[7:1]};
            end else if ({1'b0, pix.green} > {pix.blue, 1'b0}) begin
                base = WHEEL_GREEN + scale8(pix.blue, FRAC_32_85);
            end else begin
                base = WHEEL_AQUA + scale8(ssub8(pix.blue, PIVOT_85), FRAC_8_42);
            end
        end else begin
            if (pix.red == 8'd0) begin
                base = WHEEL_AQUA_BLUE + scale8(ssub8(pix.blue, PIVOT_128), FRAC_24_128);
            end else if ({1'b0, pix.blue} > {pix.red, 1'b0}) begin
                base = WHEEL_BLUE + scale8(pix.red, FRAC_32_85);
            end else begin
                base = WHEEL_PURPLE + scale8(ssub8(pix.red, PIVOT_85), FRAC_32_85);
            end
        end
    end

    assign hue = base + 8'd1;

endmodule

@@ design/rgb_to_hsv_approx_pixel.sv @@
// top level of the approximate rgb to hsv pixel converter, six-stage pipeline
// depends on rhsv_pkg, rhsv_rescale, rhsv_hue and rgb_to_hsv_approx_pixel_assert.svh
//
//   channel   handshake            payload
//   s_        s_valid / s_ready    s_red, s_green, s_blue
//   m_        m_valid / m_ready    m_hue, m_saturation, m_brightness
//
// one pixel per clock sustained while m_ready holds high; each result passes
// through the six register stages (min, table lookup, first rescale, sum and
// second lookup, second rescale and value, hue)
// every stage holds its own valid bit and only stalls when the stage after it
// is full and stalled, so bubbles close up under back pressure
// synchronous active-low reset clears the valid bits only
module rgb_to_hsv_approx_pixel (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_hue,
    output logic [7:0] m_saturation,
    output logic [7:0] m_brightness
);
    import rhsv_pkg::*;

    localparam int NSTG = 6;
    localparam int LAST = NSTG - 1;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    // stage 1: minimum removed
    rgb_t        st1_pix_reg,   st1_pix_next;
    logic [7:0]  st1_desat_reg, st1_desat_next;
    // stage 2: lookups from the minimum
    rgb_t        st2_pix_reg;
    logic [15:0] st2_k_reg,     st2_k_next;
    logic [7:0]  st2_sq_reg,    st2_sq_next;
    logic [7:0]  st2_desat_reg;
    logic        st2_grey_reg,  st2_grey_next;
    // stage 3: first rescale
    rgb_t        st3_pix_reg,   st3_pix_next;
    logic [7:0]  st3_sq_reg;
    logic [7:0]  st3_desat_reg;
    logic        st3_grey_reg;
    // stage 4: channel sum and second factor
    rgb_t        st4_pix_reg;
    logic [15:0] st4_k_reg,     st4_k_next;
    logic        st4_en_reg,    st4_en_next;
    logic [9:0]  st4_total_reg, st4_total_next;
    logic [7:0]  st4_sq_reg;
    logic [7:0]  st4_desat_reg;
    logic        st4_grey_reg;
    // stage 5: second rescale and value
    rgb_t        st5_pix_reg,   st5_pix_next;
    logic [7:0]  st5_v_reg,     st5_v_next;
    logic [7:0]  st5_sq_reg;
    logic        st5_grey_reg;
    // stage 6: output register
    logic [7:0]  hue_reg,       hue_next;
    logic [7:0]  sat_reg,       sat_next;
    logic [7:0]  bright_reg,    bright_next;

    logic [9:0]  total_fix;
    logic [10:0] v_sum;
    logic [7:0]  hue_raw;

    // stall chain: a stage moves when empty or when its successor moves
    always_comb begin
        adv[LAST] = !vld_reg[LAST] || m_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[LAST];

    // valid bits follow the data
    always_comb begin
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1 logic: smallest channel and its removal
    always_comb begin
        st1_desat_next = s_red;
        if (s_green < st1_desat_next) begin
            st1_desat_next = s_green;
        end
        if (s_blue < st1_desat_next) begin
            st1_desat_next = s_blue;
        end
        st1_pix_next.red   = s_red   - st1_desat_next;
        st1_pix_next.green = s_green - st1_desat_next;
        st1_pix_next.blue  = s_blue  - st1_desat_next;
    end

    // stage 2 logic: root of the minimum and the first factor
    // (minimum zero gives factor 257, which leaves each channel unchanged)
    always_comb begin
        st2_grey_next = (st1_pix_reg == '0);
        st2_sq_next   = SQRT_LUT[st1_desat_reg];
        st2_k_next    = KDESAT_LUT[st1_desat_reg];
    end

    // stage 3 logic: first rescale
    rhsv_rescale u_rescale_sat (
        .pix_in  (st2_pix_reg),
        .factor  (st2_k_reg),
        .enable  (1'b1),
        .pix_out (st3_pix_next)
    );

    // stage 4 logic: channel sum, second factor when the sum is below 255
    always_comb begin
        st4_total_next = 10'(st3_pix_reg.red) + 10'(st3_pix_reg.green)
                       + 10'(st3_pix_reg.blue);
        st4_en_next    = (st4_total_next < 10'd255);
        st4_k_next     = KTOTAL_LUT[st4_total_next[7:0]];
    end

    // stage 5 logic: second rescale
    rhsv_rescale u_rescale_total (
        .pix_in  (st4_pix_reg),
        .factor  (st4_k_reg),
        .enable  (st4_en_reg),
        .pix_out (st5_pix_next)
    );

    // stage 5 logic: value from minimum plus sum, saturating, then root
    always_comb begin
        total_fix = (st4_total_reg == 10'd0) ? 10'd1 : st4_total_reg;
        v_sum     = 11'(st4_desat_reg) + 11'(total_fix);
        if (st4_total_reg > 10'd255) begin
            st5_v_next = 8'hFF;
        end else if (v_sum >= 11'd255) begin
            st5_v_next = 8'hFF;
        end else begin
            st5_v_next = SQRT_LUT[v_sum[7:0]];
        end
    end

    // stage 6 logic: hue and grey override
    rhsv_hue u_hue (
        .pix (st5_pix_reg),
        .hue (hue_raw)
    );

    always_comb begin
        if (st5_grey_reg) begin
            hue_next    = WHEEL_RED;
            sat_next    = 8'd0;
            bright_next = st5_sq_reg;
        end else begin
            hue_next    = hue_raw;
            sat_next    = ~st5_sq_reg;
            bright_next = st5_v_reg;
        end
    end

    // payload registers, loaded when their stage moves
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_pix_reg   <= st1_pix_next;
            st1_desat_reg <= st1_desat_next;
        end
        if (adv[1]) begin
            st2_pix_reg   <= st1_pix_reg;
            st2_k_reg     <= st2_k_next;
            st2_sq_reg    <= st2_sq_next;
            st2_desat_reg <= st1_desat_reg;
            st2_grey_reg  <= st2_grey_next;
        end
        if (adv[2]) begin
            st3_pix_reg   <= st3_pix_next;
            st3_sq_reg    <= st2_sq_reg;
            st3_desat_reg <= st2_desat_reg;
            st3_grey_reg  <= st2_grey_reg;
        end
        if (adv[3]) begin
            st4_pix_reg   <= st3_pix_reg;
            st4_k_reg     <= st4_k_next;
            st4_en_reg    <= st4_en_next;
            st4_total_reg <= st4_total_next;
            st4_sq_reg    <= st3_sq_reg;
            st4_desat_reg <= st3_desat_reg;
            st4_grey_reg  <= st3_grey_reg;
        end
        if (adv[4]) begin
            st5_pix_reg   <= st5_pix_next;
            st5_v_reg     <= st5_v_next;
            st5_sq_reg    <= st4_sq_reg;
            st5_grey_reg  <= st4_grey_reg;
        end
        if (adv[5]) begin
            hue_reg       <= hue_next;
            sat_reg       <= sat_next;
            bright_reg    <= bright_next;
        end
    end

    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = bright_reg;

    // checks on the pipeline and the grey path
    `include "rgb_to_hsv_approx_pixel_assert.svh"

    `RHSV_ASSERT_NEXT(a_accept_fills_first, aclk, aresetn, s_valid && s_ready, vld_reg[0])
    `RHSV_ASSERT_NEXT(a_stall_holds_stage, aclk, aresetn, vld_reg[LAST-1] && !adv[LAST-1], vld_reg[LAST-1] && $stable(st5_pix_reg) && $stable(st5_v_reg))
    `RHSV_ASSERT_NOW(a_no_sat_no_hue, aclk, aresetn, m_valid && (m_saturation == 8'd0), m_hue == WHEEL_RED)

endmodule

@@ test/rgb_to_hsv_approx_pixel_tb.sv @@
// self-checking testbench for the approximate rgb to hsv pixel converter
// holds its own hsv predictor and a scoreboard of expected results
// depends on rhsv_pkg and the rgb_to_hsv_approx_pixel top level
module rgb_to_hsv_approx_pixel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhsv_pkg::*;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_t;

    // hue anchors and slopes on the 256-step wheel
    localparam int unsigned ANCHOR_RED    = 0;
    localparam int unsigned ANCHOR_ORANGE = 32;
    localparam int unsigned ANCHOR_YELLOW = 64;
    localparam int unsigned ANCHOR_GREEN  = 96;
    localparam int unsigned ANCHOR_AQUA   = 128;
    localparam int unsigned ANCHOR_BLUE   = 160;
    localparam int unsigned ANCHOR_PURPLE = 192;
    localparam int unsigned ANCHOR_PINK   = 224;
    localparam int unsigned SLOPE_32_85   = (32 * 256) / 85;
    localparam int unsigned SLOPE_32_170  = (32 * 256) / 170;
    localparam int unsigned SLOPE_8_42    = (8 * 256) / 42;
    localparam int unsigned SLOPE_24_128  = (24 * 256) / 128;
    localparam int unsigned SLOPE_48_128  = (48 * 256) / 128;
    localparam int unsigned YELLOW_RED_K  = 47;
    localparam int unsigned YELLOW_GRN_K  = 96;

    localparam int IDLE_PCT    = 24;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 16;

    // expected hsv results in pixel order
    class hsv_scoreboard;
        hsv_t expected_q[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        static function int unsigned root16(int unsigned x);
            int unsigned root;
            int unsigned cand;
            root = 0;
            for (int bitpos = 7; bitpos >= 0; bitpos--) begin
                cand = root | (1 << bitpos);
                if (cand * cand <= x) begin
                    root = cand;
                end
            end
            return root;
        endfunction

        static function int unsigned scale(int unsigned i, int unsigned k);
            return (i * (k + 1)) >> 8;
        endfunction

        static function int unsigned clamp_sub(int unsigned a, int unsigned b);
            return (a > b) ? a - b : 0;
        endfunction

        static function hsv_t predict_hsv(rgb_t px);
            int unsigned r, g, b, desat, s, v, h, total, hi, k, m, radj, gadj;
            hsv_t res;
            r = px.red;
            g = px.green;
            b = px.blue;

            // strip the common minimum
            desat = r;
            if (g < desat) desat = g;
            if (b < desat) desat = b;
            r -= desat;
            g -= desat;
            b -= desat;
            s = 255 - root16(desat * 256);

            // grey pixel
            if (r + g + b == 0) begin
                res.hue        = 8'd0;
                res.saturation = 8'd0;
                res.brightness = 8'(255 - s);
                return res;
            end

            // first rescale by 65535/s, low byte kept
            if (s < 255) begin
                if (s == 0) s = 1;
                k = 65535 / s;
                r = ((r * k) >> 8) & 8'hFF;
                g = ((g * k) >> 8) & 8'hFF;
                b = ((b * k) >> 8) & 8'hFF;
            end

            // second rescale by 65535/total
            total = r + g + b;
            if (total < 255) begin
                if (total == 0) total = 1;
                k = 65535 / total;
                r = ((r * k) >> 8) & 8'hFF;
                g = ((g * k) >> 8) & 8'hFF;
                b = ((b * k) >> 8) & 8'hFF;
            end

            // value
            if (total > 255) begin
                v = 255;
            end else begin
                v = desat + total;
                if (v > 255) v = 255;
                if (v != 255) v = root16(v * 256);
            end

            // hue by largest channel, red over green over blue on ties
            hi = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (hi == r) begin
                if (g == 0) begin
                    h = (ANCHOR_PURPLE + ANCHOR_PINK) / 2
                        + scale(clamp_sub(r, 128), SLOPE_48_128);
                end else if (r - g > g) begin
                    h = ANCHOR_RED + scale(g, SLOPE_32_85);
                end else begin
                    m = (g + 170 - r) & 8'hFF;
                    h = ANCHOR_ORANGE + scale(clamp_sub(m, 4), SLOPE_32_170);
                end
            end else if (hi == g) begin
                if (b == 0) begin
                    radj = scale(clamp_sub(171, r), YELLOW_RED_K);
                    gadj = scale(clamp_sub(g, 171), YELLOW_GRN_K);
                    h = ANCHOR_YELLOW + (((radj + gadj) & 8'hFF) >> 1);
                end else if (g - b > b) begin
                    h = ANCHOR_GREEN + scale(b, SLOPE_32_85);
                end else begin
                    h = ANCHOR_AQUA + scale(clamp_sub(b, 85), SLOPE_8_42);
                end
            end else begin
                if (r == 0) begin
                    h = ANCHOR_AQUA + (ANCHOR_BLUE - ANCHOR_AQUA) / 4
                        + scale(clamp_sub(b, 128), SLOPE_24_128);
                end else if (b - r > r) begin
                    h = ANCHOR_BLUE + scale(r, SLOPE_32_85);
                end else begin
                    h = ANCHOR_PURPLE + scale(clamp_sub(r, 85), SLOPE_32_85);
                end
            end

            res.hue        = 8'(h + 1);
            res.saturation = 8'(s);
            res.brightness = 8'(v);
            return res;
        endfunction

        function void note_pixel(rgb_t px);
            expected_q.push_back(predict_hsv(px));
        endfunction

        function void check_result(logic [7:0] hue, logic [7:0] sat, logic [7:0] bri);
            hsv_t exp_hsv;
            if (expected_q.size() == 0) begin
                $error("result transaction with no pixel pending");
                errors++;
                return;
            end
            exp_hsv = expected_q.pop_front();
            if (hue !== exp_hsv.hue) begin
                $error("hue: expected %0d, actual %0d", exp_hsv.hue, hue);
                errors++;
            end
            if (sat !== exp_hsv.saturation) begin
                $error("saturation: expected %0d, actual %0d", exp_hsv.saturation, sat);
                errors++;
            end
            if (bri !== exp_hsv.brightness) begin
                $error("brightness: expected %0d, actual %0d", exp_hsv.brightness, bri);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_red;
    logic [7:0] s_green;
    logic [7:0] s_blue;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_hue;
    logic [7:0] m_saturation;
    logic [7:0] m_brightness;

    hsv_scoreboard sb = new();

    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;
    bit hold_req    = 1'b0;

    // corners, primaries, ties, every hue branch, rescale wrap, large total
    rgb_t corner_px [24] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
        24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
        24'hC83C0A, 24'hC8960A, 24'hC8001E,
        24'h1EC80A, 24'h0AC8B4, 24'h0AC800,
        24'h001EC8, 24'h640AC8, 24'hB40AC8,
        24'h020000, 24'hFAC864, 24'hC8C800,
        24'h7F8001, 24'h80807F
    };

    rgb_to_hsv_approx_pixel i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

    always #5 aclk = ~aclk;

    // result side: random stalls, plus a long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_hue, m_saturation, m_brightness);
        end
    end

    // offer one pixel after a random gap, return at its acceptance edge
    task automatic send_pixel(input rgb_t px);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= px.red;
        s_green <= px.green;
        s_blue  <= px.blue;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_pixel(px);
    endtask

    // mix of uniform, one-zero, near-grey, tied and extreme pixels
    function automatic rgb_t random_pixel();
        rgb_t        px;
        int unsigned mode;
        int unsigned base;
        mode = $urandom_range(99);
        px.red   = 8'($urandom_range(255));
        px.green = 8'($urandom_range(255));
        px.blue  = 8'($urandom_range(255));
        if (mode < 40) begin
            return px;
        end else if (mode < 60) begin
            case ($urandom_range(2))
                0: px.red = 8'd0;
                1: px.green = 8'd0;
                default: px.blue = 8'd0;
            endcase
        end else if (mode < 75) begin
            base     = $urandom_range(247);
            px.red   = 8'(base + $urandom_range(8));
            px.green = 8'(base + $urandom_range(8));
            px.blue  = 8'(base + $urandom_range(8));
        end else if (mode < 90) begin
            case ($urandom_range(2))
                0: px.green = px.red;
                1: px.blue = px.green;
                default: px.red = px.blue;
            endcase
        end else begin
            px.red   = $urandom_range(1) ? 8'($urandom_range(1)) : 8'(255 - $urandom_range(1));
            px.green = $urandom_range(1) ? 8'($urandom_range(1)) : 8'(255 - $urandom_range(1));
            px.blue  = $urandom_range(1) ? 8'($urandom_range(1)) : 8'(255 - $urandom_range(1));
        end
        return px;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // stimulus and end of run
    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_red   <= 8'd0;
        s_green <= 8'd0;
        s_blue  <= 8'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pixels
        foreach (corner_px[i]) send_pixel(corner_px[i]);

        // random with idling on both sides
        send_random(200);

        // long stretch with no idling at all
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(150);

        // receiver holds off while pixels keep coming, pipeline fills
        hold_req = 1'b1;
        send_random(60);

        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        send_random(190);
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
